// ===== design/key_press_long_press_detector_unit_assert.svh =====
`ifndef KEY_PRESS_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH
`define KEY_PRESS_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH

// prop must hold at every edge out of reset
`define KPLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true out of reset
`define KPLP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/kplp_pkg.sv =====
`default_nettype none

package kplp_pkg;

  localparam int unsigned NumKeysDef = 6;
  localparam int unsigned TimeBitsDef = 48;

  localparam int unsigned KeyW = 3;
  localparam int unsigned MsW = 16;
  localparam int unsigned ThrW = 26;

  localparam logic [MsW-1:0] LongPressMsRst = 16'd1000;
  localparam logic [9:0] UsPerMs = 10'd1000;

  typedef struct packed {
    logic hit;
    logic is_long;
  } ev_t;

endpackage

`default_nettype wire

// ===== design/kplp_lane.sv =====
`default_nettype none
`include "key_press_long_press_detector_unit_assert.svh"

module kplp_lane #(
  parameter int unsigned TimeBits = kplp_pkg::TimeBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      acc_i,
  input  wire logic                      down_i,
  input  wire logic [TimeBits-1:0]       now_i,
  input  wire logic [kplp_pkg::ThrW-1:0] thr_i,
  output kplp_pkg::ev_t                  ev_o
);

  logic                pressed_q, pressed_d;
  logic                fired_q, fired_d;
  logic [TimeBits-1:0] time_q, time_d;
  logic [TimeBits-1:0] held;

  assign held = now_i - time_q;

  always_comb begin
    pressed_d = pressed_q;
    fired_d   = fired_q;
    time_d    = time_q;
    ev_o      = '0;
    if (down_i && !pressed_q) begin
      pressed_d = 1'b1;
      fired_d   = 1'b0;
      time_d    = now_i;
      ev_o.hit  = 1'b1;
    end else if (!down_i && pressed_q) begin
      pressed_d = 1'b0;
      fired_d   = 1'b0;
    end else if (down_i && pressed_q && !fired_q) begin
      if (held >= TimeBits'(thr_i)) begin
        fired_d      = 1'b1;
        ev_o.hit     = 1'b1;
        ev_o.is_long = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      fired_q   <= 1'b0;
    end else if (acc_i) begin
      pressed_q <= pressed_d;
      fired_q   <= fired_d;
    end
  end

  // press time is only read while pressed
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      time_q <= time_d;
    end
  end

  `KPLP_ASSERT_NEVER(a_fired_needs_press, clk_i, rst_ni, fired_q && !pressed_q, "long fired on released key")

endmodule

`default_nettype wire

// ===== design/kplp_merge.sv =====
`default_nettype none
`include "key_press_long_press_detector_unit_assert.svh"

module kplp_merge #(
  parameter int unsigned NumKeys = kplp_pkg::NumKeysDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      acc_i,
  input  kplp_pkg::ev_t [NumKeys-1:0]    ev_i,
  output logic                           rdy_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [kplp_pkg::KeyW-1:0]      event_key_o,
  output logic                           is_long_o,
  output logic                           last_event_o
);

  logic               s1_vld_q, s1_vld_d;
  logic [NumKeys-1:0] s1_hit_q, s1_lng_q;
  logic [NumKeys-1:0] pend_q, pend_d;
  logic [NumKeys-1:0] lng_q;
  logic [NumKeys-1:0] pend_rest;
  logic               busy, last, take, load;

  assign busy      = |pend_q;
  assign pend_rest = pend_q & (pend_q - NumKeys'(1));
  assign last      = ~|pend_rest;
  assign take      = busy && !out_stall_i;
  assign load      = s1_vld_q && (!busy || (take && last));
  assign rdy_o     = !s1_vld_q || load;

  assign out_valid_o  = busy;
  assign last_event_o = last;

  // lowest pending key goes first
  always_comb begin
    event_key_o = '0;
    is_long_o   = 1'b0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        event_key_o = kplp_pkg::KeyW'(i);
        is_long_o   = lng_q[i];
      end
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (acc_i) begin
      s1_vld_d = 1'b1;
    end else if (load) begin
      s1_vld_d = 1'b0;
    end
    pend_d = pend_q;
    if (load) begin
      pend_d = s1_hit_q;
    end else if (take) begin
      pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      pend_q   <= '0;
    end else begin
      s1_vld_q <= s1_vld_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      for (int i = 0; i < NumKeys; i++) begin
        s1_hit_q[i] <= ev_i[i].hit;
        s1_lng_q[i] <= ev_i[i].is_long;
      end
    end
    if (load) begin
      lng_q <= s1_lng_q;
    end
  end

  `KPLP_ASSERT(a_more_follow, clk_i, rst_ni, take && !last |=> out_valid_o, "events lost mid scan")
  `KPLP_ASSERT(a_one_per_take, clk_i, rst_ni, take && !load |=> $countones(pend_q) == $countones($past(pend_q)) - 1, "serializer dropped more than one event")
  `KPLP_ASSERT(a_hold_held, clk_i, rst_ni, s1_vld_q && !rdy_o |=> s1_vld_q && $stable(s1_hit_q) && $stable(s1_lng_q), "held scan changed")

endmodule

`default_nettype wire

// ===== design/key_press_long_press_detector_unit.sv =====
// Path: a scan taken at the input is registered in the merge hold stage, then
// loaded into the pending register, from which its first event word is sent.
// Throughput: the merge stage sends one event word per cycle while out_stall_i
// is low; the next scan waits in the hold stage until the last word is taken.
// Reset (async, active low): all keys released, no events pending,
// hold threshold 1000 ms.
`default_nettype none

module key_press_long_press_detector_unit #(
  parameter int unsigned NumKeys  = kplp_pkg::NumKeysDef,
  parameter int unsigned TimeBits = kplp_pkg::TimeBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [kplp_pkg::MsW-1:0] cfg_long_press_ms_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [NumKeys-1:0]       key_down_mask_i,
  input  wire logic [TimeBits-1:0]      now_us_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [kplp_pkg::KeyW-1:0]     event_key_o,
  output logic                          is_long_o,
  output logic                          last_event_o
);

  logic                      thr_ld;
  logic [kplp_pkg::ThrW-1:0] thr_q, thr_d;
  logic                      in_acc, mrg_rdy;
  kplp_pkg::ev_t [NumKeys-1:0] ev;

  assign cfg_ready_o = 1'b1;
  assign thr_ld      = cfg_valid_i && cfg_ready_o;
  assign thr_d       = kplp_pkg::ThrW'(cfg_long_press_ms_i) *
                       kplp_pkg::ThrW'(kplp_pkg::UsPerMs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= kplp_pkg::ThrW'(kplp_pkg::LongPressMsRst) *
               kplp_pkg::ThrW'(kplp_pkg::UsPerMs);
    end else if (thr_ld) begin
      thr_q <= thr_d;
    end
  end

  assign in_stall_o = !mrg_rdy;
  assign in_acc     = in_valid_i && mrg_rdy;

  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    kplp_lane #(
      .TimeBits(TimeBits)
    ) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .acc_i (in_acc),
      .down_i(key_down_mask_i[k]),
      .now_i (now_us_i),
      .thr_i (thr_q),
      .ev_o  (ev[k])
    );
  end

  kplp_merge #(
    .NumKeys(NumKeys)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .ev_i        (ev),
    .rdy_o       (mrg_rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_key_o (event_key_o),
    .is_long_o   (is_long_o),
    .last_event_o(last_event_o)
  );

endmodule

`default_nettype wire
